// ===== sv/ttfra_pkg.sv =====
// ----------------------------------------------------------------------------
// Text to font ROM address package
// Shared constants, glyph kind codes and the structs that pass between the
// glyph decoder and the top level.
// ----------------------------------------------------------------------------
package ttfra_pkg;

    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 18;
    localparam int KIND_W  = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    localparam logic [BYTE_W-1:0] LEAD_LO  = 8'hB0;
    localparam logic [BYTE_W-1:0] LEAD_HI  = 8'hF7;
    localparam logic [BYTE_W-1:0] TRAIL_LO = 8'hA1;
    localparam logic [BYTE_W-1:0] ASCII_LO = 8'h20;
    localparam logic [BYTE_W-1:0] ASCII_HI = 8'h7E;

    localparam logic [ADDR_W-1:0] HANZI_ROW  = 18'd94;
    localparam logic [ADDR_W-1:0] HANZI_SKIP = 18'd846;
    localparam logic [ADDR_W-1:0] A816_BASE  = 18'h3CF80;
    localparam logic [ADDR_W-1:0] A57_BASE   = 18'h3BFC0;

    localparam logic [BYTE_W-1:0] ADV_HANZI = 8'd16;
    localparam logic [BYTE_W-1:0] ADV_A816  = 8'd8;
    localparam logic [BYTE_W-1:0] ADV_A57   = 8'd6;

    localparam logic [KIND_W-1:0] KIND_HANZI = 2'd0;
    localparam logic [KIND_W-1:0] KIND_A816  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_A57   = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] held_lead;
        logic              lead_pending;
        logic [BYTE_W-1:0] cur_page;
        logic [BYTE_W-1:0] cur_column;
    } text_state_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] font_address;
        logic [KIND_W-1:0] glyph_kind;
        logic [BYTE_W-1:0] glyph_page;
        logic [BYTE_W-1:0] glyph_column;
    } glyph_result_t;

endpackage

// ===== sv/text_to_font_rom_address_core.sv =====
// ----------------------------------------------------------------------------
// Text to font ROM address core
// The result of an input transfer is registered and shown on the master side in the next cycle.
// Throughput: one byte per cycle; the single output register gives way
// whenever its result is taken in the same cycle.
// Reset: rst_n clears the font mode, the held lead, page, column and the
// output valid flag at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module text_to_font_rom_address_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // text_byte[7:0], start_page[15:8], start_column[23:16]
    input  logic [ttfra_pkg::S_DATA_W-1:0]   s_tdata,
    // string_start[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // font_address[17:0], glyph_page[25:18], glyph_column[33:26], zero fill
    output logic [ttfra_pkg::M_DATA_W-1:0]   m_tdata,
    // glyph_kind[1:0]
    output logic [ttfra_pkg::KIND_W-1:0]     m_tuser
);
    import ttfra_pkg::*;

    logic          font_mode_reg;
    text_state_t   state_reg;
    text_state_t   state_next;
    glyph_result_t result;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [BYTE_W-1:0] out_page_reg;
    logic [BYTE_W-1:0] out_column_reg;
    logic          in_xfer;

    ttfra_glyph_decode u_decode (
        .font_mode    (font_mode_reg),
        .state_cur    (state_reg),
        .text_byte    (s_tdata[7:0]),
        .string_start (s_tuser),
        .start_page   (s_tdata[15:8]),
        .start_column (s_tdata[23:16]),
        .result       (result),
        .state_next   (state_next)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_xfer)
        begin
            out_valid_next = result.valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_mode_reg <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                font_mode_reg <= cfg_wr_data;
            end
            if (in_xfer)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_addr_reg   <= result.font_address;
            out_kind_reg   <= result.glyph_kind;
            out_page_reg   <= result.glyph_page;
            out_column_reg <= result.glyph_column;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_column_reg, out_page_reg, out_addr_reg};
    assign m_tuser  = out_kind_reg;

endmodule

// ===== sv/ttfra_glyph_decode.sv =====
// ----------------------------------------------------------------------------
// Glyph decoder
// Classifies one text byte against the held lead state and the font mode,
// and forms the glyph result and the next text state.
// ----------------------------------------------------------------------------
module ttfra_glyph_decode (
    input  logic                           font_mode,
    input  ttfra_pkg::text_state_t         state_cur,
    input  logic [ttfra_pkg::BYTE_W-1:0]   text_byte,
    input  logic                           string_start,
    input  logic [ttfra_pkg::BYTE_W-1:0]   start_page,
    input  logic [ttfra_pkg::BYTE_W-1:0]   start_column,
    output ttfra_pkg::glyph_result_t       result,
    output ttfra_pkg::text_state_t         state_next
);
    import ttfra_pkg::*;

    text_state_t       st;
    logic              is_ascii;
    logic              is_lead;
    logic              is_trail;
    logic [BYTE_W-1:0] advance;
    logic [ADDR_W-1:0] ascii_off;
    logic [ADDR_W-1:0] hanzi_code;

    always_comb
    begin
        st = state_cur;
        if (string_start)
        begin
            st.cur_page     = start_page;
            st.cur_column   = start_column;
            st.lead_pending = 1'b0;
        end

        is_ascii   = (text_byte >= ASCII_LO) && (text_byte <= ASCII_HI);
        is_lead    = (text_byte >= LEAD_LO) && (text_byte <= LEAD_HI);
        is_trail   = (text_byte >= TRAIL_LO);
        ascii_off  = ADDR_W'(text_byte - ASCII_LO);
        hanzi_code = ADDR_W'(st.held_lead - LEAD_LO) * HANZI_ROW
                   + ADDR_W'(text_byte - TRAIL_LO) + HANZI_SKIP;

        result.valid        = 1'b0;
        result.font_address = '0;
        result.glyph_kind   = KIND_A816;
        result.glyph_page   = st.cur_page;
        result.glyph_column = st.cur_column;
        advance             = '0;
        state_next          = st;
        state_next.lead_pending = 1'b0;

        if (font_mode)
        begin
            if (is_ascii)
            begin
                result.valid        = 1'b1;
                result.font_address = (ascii_off << 3) + A57_BASE;
                result.glyph_kind   = KIND_A57;
                advance             = ADV_A57;
            end
        end
        else if (st.lead_pending && is_trail)
        begin
            result.valid        = 1'b1;
            result.font_address = hanzi_code << 5;
            result.glyph_kind   = KIND_HANZI;
            advance             = ADV_HANZI;
        end
        else if (is_lead)
        begin
            state_next.held_lead    = text_byte;
            state_next.lead_pending = 1'b1;
        end
        else if (is_ascii)
        begin
            result.valid        = 1'b1;
            result.font_address = (ascii_off << 4) + A816_BASE;
            result.glyph_kind   = KIND_A816;
            advance             = ADV_A816;
        end

        state_next.cur_column = st.cur_column + advance;
    end

endmodule

// ===== sv/ttfra_checker.sv =====
// ----------------------------------------------------------------------------
// Text to font ROM address checker
// Port-level checks on the output register behavior and glyph results,
// bound to the top level.
// ----------------------------------------------------------------------------
module ttfra_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [ttfra_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic [ttfra_pkg::KIND_W-1:0]     m_tuser
);
    import ttfra_pkg::*;

    // A stalled result keeps its payload until the transfer.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // The input side never stalls while the output register is empty or drains.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled without backpressure");

    // Glyph addresses are aligned to the glyph size of their kind.
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == KIND_HANZI && m_tdata[4:0] == 5'd0)
                  || (m_tuser == KIND_A816 && m_tdata[3:0] == 4'd0)
                  || (m_tuser == KIND_A57 && m_tdata[2:0] == 3'd0))
        else $error("misaligned glyph address");

    // The fill bits above the glyph column stay zero.
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_DATA_W-1:34] == '0)
        else $error("nonzero fill in result data");

endmodule

bind text_to_font_rom_address_core ttfra_checker u_ttfra_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== verif/text_to_font_rom_address_core_tb.sv =====
// ----------------------------------------------------------------------------
// Text to font ROM address core testbench
// Streams text bytes through the core in both font modes and checks every
// glyph address, kind, page and column against a cycle-free predictor. The
// byte sender and the glyph receiver idle and stall at random in several
// phases, with one long receiver hold-off that backs the core up.
// ----------------------------------------------------------------------------
module text_to_font_rom_address_core_tb;

    import ttfra_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              string_start;
        logic [BYTE_W-1:0] start_page;
        logic [BYTE_W-1:0] start_column;
    } text_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] font_address;
        logic [KIND_W-1:0] glyph_kind;
        logic [BYTE_W-1:0] glyph_page;
        logic [BYTE_W-1:0] glyph_column;
    } glyph_t;

    localparam int HOLD_CYCLES = 300;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_wr_data = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]   m_tuser;

    text_item_t text_q[$];
    glyph_t     glyph_q[$];

    logic              shadow_mode = 1'b0;
    logic [BYTE_W-1:0] shadow_lead = '0;
    logic              shadow_lead_valid = 1'b0;
    logic [BYTE_W-1:0] shadow_page = '0;
    logic [BYTE_W-1:0] shadow_column = '0;

    logic byte_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_req = 1'b0;
    int   hold_left = 0;
    int   err_count = 0;

    text_to_font_rom_address_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #10 clk = ~clk;

    task automatic push_glyph(input int addr, input logic [KIND_W-1:0] kind,
                              input logic [BYTE_W-1:0] advance);
        glyph_t g;
        g.font_address = addr[ADDR_W-1:0];
        g.glyph_kind   = kind;
        g.glyph_page   = shadow_page;
        g.glyph_column = shadow_column;
        glyph_q.push_back(g);
        shadow_column = shadow_column + advance;
    endtask

    task automatic predict_glyph(input text_item_t it);
        int  c;
        logic handled;
        c = int'(it.text_byte);
        handled = 1'b0;
        if (it.string_start)
        begin
            shadow_page       = it.start_page;
            shadow_column     = it.start_column;
            shadow_lead_valid = 1'b0;
        end
        if (shadow_mode)
        begin
            shadow_lead_valid = 1'b0;
            if (c >= int'(ASCII_LO) && c <= int'(ASCII_HI))
                push_glyph((c - int'(ASCII_LO)) * 8 + int'(A57_BASE), KIND_A57, ADV_A57);
        end
        else
        begin
            if (shadow_lead_valid)
            begin
                shadow_lead_valid = 1'b0;
                if (c >= int'(TRAIL_LO))
                begin
                    push_glyph(((int'(shadow_lead) - int'(LEAD_LO)) * int'(HANZI_ROW)
                                + (c - int'(TRAIL_LO)) + int'(HANZI_SKIP)) * 32,
                               KIND_HANZI, ADV_HANZI);
                    handled = 1'b1;
                end
            end
            if (!handled)
            begin
                if (c >= int'(LEAD_LO) && c <= int'(LEAD_HI))
                begin
                    shadow_lead       = it.text_byte;
                    shadow_lead_valid = 1'b1;
                end
                else if (c >= int'(ASCII_LO) && c <= int'(ASCII_HI))
                    push_glyph((c - int'(ASCII_LO)) * 16 + int'(A816_BASE), KIND_A816,
                               ADV_A816);
            end
        end
    endtask

    // Byte sender: a new transfer is offered only once the previous one is taken.
    always @(negedge clk)
    begin
        text_item_t it;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || byte_taken)
        begin
            if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                it = text_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {it.start_column, it.start_page, it.text_byte};
                s_tuser  <= it.string_start;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        text_item_t it;
        glyph_t     want;
        glyph_t     got;
        byte_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            it.text_byte    = s_tdata[7:0];
            it.start_page   = s_tdata[15:8];
            it.start_column = s_tdata[23:16];
            it.string_start = s_tuser;
            predict_glyph(it);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.font_address = m_tdata[17:0];
            got.glyph_page   = m_tdata[25:18];
            got.glyph_column = m_tdata[33:26];
            got.glyph_kind   = m_tuser;
            if (glyph_q.size() == 0)
            begin
                $display("%0t: unexpected glyph, expected none,", $time,
                         " actual addr=%h kind=%0d page=%0d col=%0d",
                         got.font_address, got.glyph_kind, got.glyph_page,
                         got.glyph_column);
                err_count++;
            end
            else
            begin
                want = glyph_q.pop_front();
                if (got.font_address !== want.font_address
                    || got.glyph_kind !== want.glyph_kind
                    || got.glyph_page !== want.glyph_page
                    || got.glyph_column !== want.glyph_column)
                begin
                    $display("%0t: glyph mismatch, expected addr=%h kind=%0d page=%0d col=%0d,",
                             $time, want.font_address, want.glyph_kind, want.glyph_page,
                             want.glyph_column,
                             " actual addr=%h kind=%0d page=%0d col=%0d",
                             got.font_address, got.glyph_kind,
                             got.glyph_page, got.glyph_column);
                    err_count++;
                end
            end
        end
    end

    task automatic queue_byte(input logic [BYTE_W-1:0] c, input logic start,
                              input logic [BYTE_W-1:0] page, input logic [BYTE_W-1:0] col);
        text_item_t it;
        it.text_byte    = c;
        it.string_start = start;
        it.start_page   = page;
        it.start_column = col;
        text_q.push_back(it);
    endtask

    task automatic queue_text(input logic [BYTE_W-1:0] c);
        queue_byte(c, ($urandom_range(99) < 6), BYTE_W'($urandom_range(255)),
                   BYTE_W'($urandom_range(255)));
    endtask

    task automatic queue_random_text();
        int pick;
        logic [BYTE_W-1:0] lead;
        pick = $urandom_range(99);
        lead = BYTE_W'($urandom_range(LEAD_HI, LEAD_LO));
        if (pick < 40)
            queue_text(BYTE_W'($urandom_range(ASCII_HI, ASCII_LO)));
        else if (pick < 70)
        begin
            queue_text(lead);
            queue_text(BYTE_W'($urandom_range(255, TRAIL_LO)));
        end
        else if (pick < 78)
        begin
            queue_text(lead);
            queue_text(BYTE_W'($urandom_range(TRAIL_LO - 1, 0)));
        end
        else if (pick < 84)
            queue_text(8'h00);
        else
            queue_text(BYTE_W'($urandom_range(255)));
    endtask

    task automatic write_font_mode(input logic m);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        shadow_mode = m;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (text_q.size() != 0 || s_tvalid || glyph_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        int send_pct[4] = '{0, 75, 0, 28};
        int recv_pct[4] = '{0, 0, 75, 28};
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_font_mode(1'b0);
        set_idling(0, 0);
        queue_byte(8'h20, 1'b1, 8'hFF, 8'hFA);
        queue_byte(8'h7E, 1'b0, 8'h00, 8'h00);
        queue_byte(8'hB0, 1'b0, 8'h00, 8'h00);
        queue_byte(8'hA1, 1'b0, 8'h00, 8'h00);
        queue_byte(8'hF7, 1'b0, 8'hFF, 8'hFF);
        queue_byte(8'hFF, 1'b0, 8'hFF, 8'hFF);
        queue_byte(8'hB0, 1'b0, 8'h00, 8'h00);
        queue_byte(8'h41, 1'b0, 8'h00, 8'h00);
        queue_byte(8'hC0, 1'b0, 8'h00, 8'h00);
        queue_byte(8'hD0, 1'b0, 8'h00, 8'h00);
        queue_byte(8'hB5, 1'b0, 8'h00, 8'h00);
        queue_byte(8'h00, 1'b0, 8'h00, 8'h00);
        queue_byte(8'h41, 1'b0, 8'h00, 8'h00);
        queue_byte(8'h7F, 1'b0, 8'h00, 8'h00);
        queue_byte(8'h1F, 1'b0, 8'h00, 8'h00);
        queue_byte(8'hA0, 1'b0, 8'h00, 8'h00);
        queue_byte(8'hFF, 1'b0, 8'h00, 8'h00);
        queue_byte(8'hF8, 1'b0, 8'h00, 8'h00);
        queue_byte(8'hE0, 1'b0, 8'h00, 8'h00);
        queue_byte(8'hA2, 1'b1, 8'h00, 8'h00);
        queue_byte(8'h5A, 1'b0, 8'h00, 8'h00);
        queue_byte(8'hC1, 1'b0, 8'h00, 8'h00);
        wait_drained();

        // The lead byte held above must be dropped by the first byte in 5x7 mode.
        write_font_mode(1'b1);
        queue_byte(8'hA5, 1'b0, 8'h00, 8'h00);
        queue_byte(8'h20, 1'b1, 8'h7E, 8'hFD);
        queue_byte(8'h7E, 1'b0, 8'h00, 8'h00);
        queue_byte(8'hB0, 1'b0, 8'h00, 8'h00);
        queue_byte(8'h00, 1'b0, 8'h00, 8'h00);
        queue_byte(8'h41, 1'b0, 8'h00, 8'h00);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            write_font_mode(p % 3 == 2);
            set_idling(send_pct[p % 4], recv_pct[p % 4]);
            if (p == 0)
                hold_req = 1'b1;
            queue_text(8'h41);
            text_q[0].string_start = 1'b1;
            while (text_q.size() < 75)
                queue_random_text();
            wait_drained();
        end

        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
